### rtl/sbm_pkg.sv
// Shared constants and defaults for the spectrum bar level meter.
`timescale 1ns / 1ps
package sbm_pkg;

    // Default sizes
    localparam int MAX_BARS_DEF      = 128;
    localparam int SPECTRUM_BINS_DEF = 256;
    localparam int HEIGHT_BITS_DEF   = 12;

    // Field widths
    localparam int MAG_W      = 24;
    localparam int MUL_W      = 25;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_BAR_COUNT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE_BITS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK_RATE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DECAY_RATE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DB_FLOOR    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DB_CEILING  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_COL_HEIGHT  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_FALL   = 3'd7;

    // Register reset values
    localparam logic [7:0]  BAR_COUNT_RST = 8'd32;
    localparam logic [4:0]  MODE_RST      = 5'd1;
    localparam logic [15:0] ATTACK_RST    = 16'd32768;
    localparam logic [15:0] DECAY_RST     = 16'd6554;
    localparam logic [7:0]  FLOOR_RST     = 8'hC4;   // -60 dB
    localparam logic [7:0]  CEILING_RST   = 8'h00;
    localparam int          COL_H_RST     = 256;
    localparam logic [9:0]  FALL_RST      = 10'd32;

    // Channel select codes
    localparam logic [1:0] CH_LEFT  = 2'd1;
    localparam logic [1:0] CH_RIGHT = 2'd2;

    // dB arithmetic
    localparam int DB_SILENCE    = -30720;    // -120 dB in Q8.8
    localparam int LOG2_40_OFS   = 1397354;   // log2(40) + 16, Q16
    localparam int DB_PER_OCTAVE = 394566;    // 20*log10(2), Q16
    localparam int RELEASE_Q8    = 51;
    localparam int TOP_CLEAR     = 2;

endpackage

### rtl/sbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sbm_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module sbm_mul import sbm_pkg::*; (
    input  logic                      aclk,
    input  logic signed [MUL_W-1:0]   mul_a,
    input  logic signed [MUL_W-1:0]   mul_b,
    output logic signed [2*MUL_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

### rtl/sbm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sbm_div #(
    parameter int DVD_W = 34,
    parameter int DSR_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done_reg,
    output logic [DVD_W-1:0] quot_reg
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W:0]   rem_sh;
    logic             q_bit;
    logic [DSR_W:0]   rem_diff;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh   = {rem_reg, quot_reg[DVD_W-1]};
        rem_diff = rem_sh - {1'b0, dsr_reg};
        q_bit    = (rem_sh >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out as the quotient shifts in
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[DVD_W-2:0], q_bit};
            rem_reg  <= q_bit ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
        end
    end

endmodule

### rtl/spectrum_bar_level_meter.sv
// Spectrum bar level meter top level: sequencer and per-bar datapath.
`timescale 1ns / 1ps
// Bins are accepted one per cycle while the block is idle; a bin that does not
// close a bar only updates the accumulator. A closing bin starts a sequence on
// a shared multiplier and a one-bit-per-cycle divider: the bar mean divide,
// optional smoothing, then in dB mode the dB log (16 squaring rounds, skipped
// for a zero level) and the dB height divide (skipped when the height clamps to
// zero or full), or in linear mode a height multiply; then the result, after
// any wait on m_tready for the previous result. The divider length (dividend
// width) and the log squaring loop set the length of this sequence. Per-bar
// state sits in two RAMs (smoothed level; peak and ceiling). After reset and
// after each write of bar_count or column_height a clearing pass over all
// MAX_BARS entries rewrites the affected ones, and s_tready stays low meanwhile.
module spectrum_bar_level_meter import sbm_pkg::*; #(
    parameter int MAX_BARS      = MAX_BARS_DEF,
    parameter int SPECTRUM_BINS = SPECTRUM_BINS_DEF,
    parameter int HEIGHT_BITS   = HEIGHT_BITS_DEF,
    localparam int IDX_W        = $clog2(MAX_BARS),
    localparam int OUT_W        = ((IDX_W + 2 * HEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input bins
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,    // mag_left, mag_right
    input  logic                  s_tlast,    // closes_bar
    input  logic                  s_tuser,    // frame_start
    // bar results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,    // bar_index, bar_height, peak_height
    output logic                  m_tlast,    // last_bar
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int HB      = HEIGHT_BITS;
    localparam int TALLY_W = $clog2(SPECTRUM_BINS + 1);
    localparam int SUM_W   = MAG_W + 1 + TALLY_W;
    localparam int DVD_W   = (SUM_W > HB + 18) ? SUM_W : HB + 18;
    localparam int DSR_W   = (TALLY_W + 1 > 17) ? TALLY_W + 1 : 17;
    localparam int PK_W    = HB + 4;
    localparam int PC_W    = PK_W + 16;
    localparam int PW      = 2 * MUL_W;

    localparam logic signed [17:0] DB_SIL18 = 18'(DB_SILENCE);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_DIV    = 16'h0002,
        S_SMUL   = 16'h0004,
        S_SMOOTH = 16'h0008,
        S_LOGN   = 16'h0010,
        S_LSQ    = 16'h0020,
        S_LACC   = 16'h0040,
        S_DBMUL  = 16'h0080,
        S_DB     = 16'h0100,
        S_GAIN   = 16'h0200,
        S_HMUL   = 16'h0400,
        S_HDIV   = 16'h0800,
        S_HWAIT  = 16'h1000,
        S_LMUL   = 16'h2000,
        S_LIN    = 16'h4000,
        S_FIN    = 16'h8000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [7:0]         bar_count_reg;
    logic [4:0]         mode_reg;
    logic [15:0]        atk_reg;
    logic [15:0]        dec_reg;
    logic [7:0]         floor_reg;
    logic [7:0]         ceil_reg;
    logic [HB-1:0]      colh_reg;
    logic [9:0]         fall_reg;
    logic signed [15:0] clr_ceil_reg;

    // accumulator and bar counter
    logic [SUM_W-1:0]   sum_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [IDX_W-1:0]   cur_bar_reg;
    logic [IDX_W-1:0]   idx_reg;

    // clearing pass
    logic               clr_busy_reg;
    logic               clr_sm_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;

    // datapath
    logic [MAG_W-1:0]   raw_reg;
    logic [MAG_W-1:0]   x_reg;
    logic [MAG_W-1:0]   sm_reg;
    logic signed [15:0] cl_reg;
    logic [PK_W-1:0]    pk_reg;
    logic [4:0]         e_reg;
    logic [MAG_W-1:0]   m_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         it_reg;
    logic signed [17:0] db_reg;
    logic [16:0]        range_reg;
    logic [16:0]        num_reg;
    logic [HB-1:0]      hgt_reg;

    // output register
    logic               m_valid_reg;
    logic [IDX_W-1:0]   idx_out_reg;
    logic [HB-1:0]      hgt_out_reg;
    logic [HB-1:0]      pk_out_reg;
    logic               last_out_reg;

    // shared units
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [PW-1:0]    prod_reg;
    logic                    div_start;
    logic [DVD_W-1:0]        div_dvd;
    logic [DSR_W-1:0]        div_dsr;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quot;

    logic                    sm_we;
    logic [MAG_W-1:0]        sm_wdata;
    logic [MAG_W-1:0]        sm_rdata;
    logic                    pc_we;
    logic [PC_W-1:0]         pc_wdata;
    logic [PC_W-1:0]         pc_rdata;
    logic [IDX_W-1:0]        ram_waddr;

    sbm_mul u_mul (
        .aclk     (aclk),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod_reg (prod_reg)
    );

    sbm_div #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done_reg (div_done),
        .quot_reg (div_quot)
    );

    sbm_ram #(
        .WIDTH (MAG_W),
        .DEPTH (MAX_BARS)
    ) u_sm_ram (
        .aclk  (aclk),
        .we    (sm_we),
        .waddr (ram_waddr),
        .wdata (sm_wdata),
        .raddr (idx_reg),
        .rdata (sm_rdata)
    );

    sbm_ram #(
        .WIDTH (PC_W),
        .DEPTH (MAX_BARS)
    ) u_pc_ram (
        .aclk  (aclk),
        .we    (pc_we),
        .waddr (ram_waddr),
        .wdata (pc_wdata),
        .raddr (idx_reg),
        .rdata (pc_rdata)
    );

    // active bar count, clamped
    logic [8:0] n_bars;
    always_comb begin
        if (bar_count_reg < 8'd8) begin
            n_bars = 9'd8;
        end else if ({1'b0, bar_count_reg} > 9'(MAX_BARS)) begin
            n_bars = 9'(MAX_BARS);
        end else begin
            n_bars = {1'b0, bar_count_reg};
        end
    end

    // bin intake
    logic                 in_acc;
    logic [MAG_W-1:0]     mag_l;
    logic [MAG_W-1:0]     mag_r;
    logic [MAG_W:0]       bin_v;
    logic [IDX_W-1:0]     cur_eff;
    logic [SUM_W-1:0]     sum_base;
    logic [TALLY_W-1:0]   tally_base;
    logic [SUM_W-1:0]     sum_new;
    logic [TALLY_W-1:0]   tally_new;

    always_comb begin
        in_acc     = s_tvalid && s_tready;
        mag_l      = s_tdata[MAG_W-1:0];
        mag_r      = s_tdata[2*MAG_W-1:MAG_W];
        cur_eff    = s_tuser ? '0 : cur_bar_reg;
        if (9'(cur_eff) >= n_bars) begin
            cur_eff = '0;
        end
        sum_base   = s_tuser ? '0 : sum_reg;
        tally_base = s_tuser ? '0 : tally_reg;
        case (mode_reg[4:3])
            CH_LEFT:  bin_v = {mag_l, 1'b0};
            CH_RIGHT: bin_v = {mag_r, 1'b0};
            default:  bin_v = {1'b0, mag_l} + {1'b0, mag_r};
        endcase
        if (tally_base < TALLY_W'(SPECTRUM_BINS)) begin
            sum_new   = sum_base + SUM_W'(bin_v);
            tally_new = tally_base + 1'b1;
        end else begin
            sum_new   = sum_base;
            tally_new = tally_base;
        end
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_dvd   = DVD_W'(sum_new);
        div_dsr   = DSR_W'({tally_new, 1'b0});
        if (state_reg == S_IDLE) begin
            div_start = in_acc && s_tlast;
        end else if (state_reg == S_HDIV) begin
            div_start = 1'b1;
            div_dvd   = DVD_W'({prod_reg[HB+15:0], 1'b0}) + DVD_W'(range_reg);
            div_dsr   = DSR_W'({range_reg, 1'b0});
        end
    end

    // bar mean, clamped to Q8.16
    logic [MAG_W-1:0] raw_val;
    assign raw_val = (|div_quot[DVD_W-1:MAG_W]) ? '1 : div_quot[MAG_W-1:0];

    // per-bar entry fields
    logic [MAG_W-1:0]   ent_sm;
    logic signed [15:0] ent_cl;
    logic [PK_W-1:0]    ent_pk;
    always_comb begin
        ent_sm = sm_rdata;
        ent_cl = signed'(pc_rdata[15:0]);
        ent_pk = pc_rdata[PC_W-1:16];
    end

    // smoothing step
    logic             sm_rise;
    logic [40:0]      sm_sum;
    logic [MAG_W-1:0] sm_new;
    always_comb begin
        sm_rise = (raw_reg >= sm_reg);
        sm_sum  = 41'(prod_reg[39:0]) + 41'd32768;
        sm_new  = sm_rise ? sm_reg + sm_sum[39:16] : sm_reg - sm_sum[39:16];
    end

    // leading one of the level
    logic [4:0] lead_e;
    always_comb begin
        lead_e = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (x_reg[i]) begin
                lead_e = 5'(i);
            end
        end
    end

    // squaring round result
    logic [MAG_W:0] sq;
    assign sq = prod_reg[2*MAG_W-1:MAG_W-1];

    // log offset and dB rounding
    logic signed [22:0] log_t;
    logic signed [PW-1:0] db_sum;
    logic signed [25:0] db_q;
    always_comb begin
        log_t  = signed'({2'b00, e_reg, frac_reg}) - 23'sd1397354;
        db_sum = prod_reg + PW'(64'sd8388608);
        db_q   = db_sum[PW-1:24];
    end

    // auto gain and dB span
    logic signed [18:0] db19, flo19, cf19, c0, c1, c1d, c2, c3, lo19, ceil_use;
    logic signed [18:0] range19, num19;
    always_comb begin
        db19  = 19'(db_reg);
        flo19 = 19'(signed'({floor_reg, 8'h00}));
        cf19  = 19'(signed'({ceil_reg, 8'h00}));
        c0    = 19'(cl_reg);
        c1d   = c0 - 19'sd51;
        if (db19 > c0) begin
            c1 = db19;
        end else begin
            c1 = (c1d < db19) ? db19 : c1d;
        end
        lo19     = flo19 + 19'sd256;
        c2       = (c1 < lo19) ? lo19 : c1;
        c3       = (c2 > 19'sd0) ? 19'sd0 : c2;
        ceil_use = mode_reg[2] ? c3 : cf19;
        range19  = ceil_use - flo19;
        if (range19 < 19'sd256) begin
            range19 = 19'sd256;
        end
        num19 = db19 - flo19;
    end

    // linear height
    logic [HB+24:0] lin_sum;
    assign lin_sum = (HB+25)'(prod_reg[HB+23:0]) + (HB+25)'(32768);

    // cap, peak and frame position
    logic [HB-1:0]   h_cap;
    logic [HB-1:0]   hgt_fin;
    logic [PK_W-1:0] bar16;
    logic [PK_W-1:0] pk_new;
    logic [PK_W:0]   pk_rnd;
    logic            is_last;
    always_comb begin
        h_cap   = (colh_reg > HB'(TOP_CLEAR)) ? colh_reg - HB'(TOP_CLEAR) : '0;
        hgt_fin = (hgt_reg > h_cap) ? h_cap : hgt_reg;
        bar16   = {hgt_fin, 4'h0};
        if (bar16 > pk_reg) begin
            pk_new = bar16;
        end else if (pk_reg - bar16 > PK_W'(fall_reg)) begin
            pk_new = pk_reg - PK_W'(fall_reg);
        end else begin
            pk_new = bar16;
        end
        if (pk_new > {h_cap, 4'h0}) begin
            pk_new = {h_cap, 4'h0};
        end
        pk_rnd  = {1'b0, pk_new} + (PK_W+1)'(8);
        is_last = (9'(idx_reg) + 9'd1 >= n_bars);
    end

    logic fin_go;
    assign fin_go = (state_reg == S_FIN) && (!m_valid_reg || m_tready);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SMUL: begin
                mul_a = MUL_W'(sm_rise ? atk_reg : dec_reg);
                mul_b = MUL_W'(sm_rise ? raw_reg - sm_reg : sm_reg - raw_reg);
            end
            S_LSQ: begin
                mul_a = MUL_W'(m_reg);
                mul_b = MUL_W'(m_reg);
            end
            S_DBMUL: begin
                mul_a = MUL_W'(log_t);
                mul_b = MUL_W'(DB_PER_OCTAVE);
            end
            S_HMUL: begin
                mul_a = MUL_W'(num_reg);
                mul_b = MUL_W'(colh_reg);
            end
            S_LMUL: begin
                mul_a = MUL_W'(x_reg);
                mul_b = MUL_W'(colh_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // RAM write: clearing pass or bar write-back
    always_comb begin
        ram_waddr = clr_busy_reg ? clr_cnt_reg : idx_reg;
        sm_we     = clr_busy_reg ? clr_sm_reg : fin_go;
        pc_we     = clr_busy_reg || fin_go;
        sm_wdata  = clr_busy_reg ? '0 : sm_reg;
        pc_wdata  = clr_busy_reg ? {PK_W'(0), clr_ceil_reg} : {pk_new, cl_reg};
    end

    // clearing pass sequencing
    logic cfg_clear;
    assign cfg_clear = cfg_wr_en && (cfg_addr == CFG_BAR_COUNT || cfg_addr == CFG_COL_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_sm_reg   <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            if (cfg_clear) begin
                clr_busy_reg <= 1'b1;
                clr_cnt_reg  <= '0;
                clr_sm_reg   <= (cfg_addr == CFG_BAR_COUNT) || (clr_busy_reg && clr_sm_reg);
            end else if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(MAX_BARS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fin_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // sequencer, counters and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            bar_count_reg <= BAR_COUNT_RST;
            mode_reg      <= MODE_RST;
            atk_reg       <= ATTACK_RST;
            dec_reg       <= DECAY_RST;
            floor_reg     <= FLOOR_RST;
            ceil_reg      <= CEILING_RST;
            colh_reg      <= HB'(COL_H_RST);
            fall_reg      <= FALL_RST;
            clr_ceil_reg  <= signed'({CEILING_RST, 8'h00});
            sum_reg       <= '0;
            tally_reg     <= '0;
            cur_bar_reg   <= '0;
            it_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BAR_COUNT: begin
                        bar_count_reg <= cfg_data[7:0];
                        sum_reg       <= '0;
                        tally_reg     <= '0;
                        cur_bar_reg   <= '0;
                        clr_ceil_reg  <= signed'({ceil_reg, 8'h00});
                    end
                    CFG_MODE_BITS:   mode_reg  <= cfg_data[4:0];
                    CFG_ATTACK_RATE: atk_reg   <= cfg_data[15:0];
                    CFG_DECAY_RATE:  dec_reg   <= cfg_data[15:0];
                    CFG_DB_FLOOR:    floor_reg <= cfg_data[7:0];
                    CFG_DB_CEILING:  ceil_reg  <= cfg_data[7:0];
                    CFG_COL_HEIGHT: begin
                        colh_reg     <= cfg_data[HB-1:0];
                        clr_ceil_reg <= signed'({ceil_reg, 8'h00});
                    end
                    CFG_PEAK_FALL:   fall_reg  <= cfg_data[9:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        cur_bar_reg <= cur_eff;
                        if (s_tlast) begin
                            sum_reg   <= '0;
                            tally_reg <= '0;
                            state_reg <= S_DIV;
                        end else begin
                            sum_reg   <= sum_new;
                            tally_reg <= tally_new;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (mode_reg[1]) begin
                            state_reg <= S_SMUL;
                        end else if (mode_reg[0]) begin
                            state_reg <= S_LOGN;
                        end else begin
                            state_reg <= S_LMUL;
                        end
                    end
                end
                S_SMUL:   state_reg <= S_SMOOTH;
                S_SMOOTH: state_reg <= mode_reg[0] ? S_LOGN : S_LMUL;
                S_LOGN: begin
                    it_reg    <= '0;
                    state_reg <= (x_reg == '0) ? S_GAIN : S_LSQ;
                end
                S_LSQ: state_reg <= S_LACC;
                S_LACC: begin
                    it_reg    <= it_reg + 1'b1;
                    state_reg <= (it_reg == 4'd15) ? S_DBMUL : S_LSQ;
                end
                S_DBMUL: state_reg <= S_DB;
                S_DB:    state_reg <= S_GAIN;
                S_GAIN: begin
                    if (num19 <= 19'sd0 || num19 >= range19) begin
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_HMUL;
                    end
                end
                S_HMUL: state_reg <= S_HDIV;
                S_HDIV: state_reg <= S_HWAIT;
                S_HWAIT: begin
                    if (div_done) begin
                        state_reg <= S_FIN;
                    end
                end
                S_LMUL: state_reg <= S_LIN;
                S_LIN:  state_reg <= S_FIN;
                S_FIN: begin
                    if (fin_go) begin
                        cur_bar_reg <= is_last ? '0 : IDX_W'(9'(idx_reg) + 9'd1);
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_acc && s_tlast) begin
                    idx_reg <= cur_eff;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    raw_reg <= raw_val;
                    x_reg   <= raw_val;
                    sm_reg  <= ent_sm;
                    cl_reg  <= ent_cl;
                    pk_reg  <= ent_pk;
                end
            end
            S_SMOOTH: begin
                sm_reg <= sm_new;
                x_reg  <= sm_new;
            end
            S_LOGN: begin
                db_reg   <= DB_SIL18;
                e_reg    <= lead_e;
                m_reg    <= x_reg << (5'd23 - lead_e);
                frac_reg <= '0;
            end
            S_LACC: begin
                frac_reg <= {frac_reg[14:0], sq[MAG_W]};
                m_reg    <= sq[MAG_W] ? sq[MAG_W:1] : sq[MAG_W-1:0];
            end
            S_DB: begin
                db_reg <= (db_q < 26'(DB_SILENCE)) ? DB_SIL18 : db_q[17:0];
            end
            S_GAIN: begin
                if (mode_reg[2]) begin
                    cl_reg <= c3[15:0];
                end
                range_reg <= range19[16:0];
                num_reg   <= num19[16:0];
                if (num19 <= 19'sd0) begin
                    hgt_reg <= '0;
                end else begin
                    hgt_reg <= colh_reg;
                end
            end
            S_HWAIT: begin
                if (div_done) begin
                    hgt_reg <= div_quot[HB-1:0];
                end
            end
            S_LIN: begin
                hgt_reg <= (x_reg >= 24'd65536) ? colh_reg : lin_sum[HB+15:16];
            end
            S_FIN: begin
                if (fin_go) begin
                    idx_out_reg  <= idx_reg;
                    hgt_out_reg  <= hgt_fin;
                    pk_out_reg   <= pk_rnd[HB+3:4];
                    last_out_reg <= is_last;
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({pk_out_reg, hgt_out_reg, idx_out_reg});
    assign m_tlast  = last_out_reg;

endmodule

### tb/sv/tb_spectrum_bar_level_meter.sv
// Testbench for the spectrum bar level meter: random bins checked against a bar predictor.
`timescale 1ns / 1ps
module tb_spectrum_bar_level_meter;
    import sbm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 200;   // extra wait at the end of drain()

    typedef struct packed {
        bit [6:0]  idx;
        bit [11:0] height;
        bit [11:0] peak;
        bit        last;
    } bar_result_t;

    // Predicts the bar results from accepted bins and register writes
    class bar_meter_scoreboard;
        bit [7:0]  bar_count;
        bit [4:0]  mode;
        bit [15:0] attack, decay;
        bit [7:0]  floor_db, ceil_db;
        bit [11:0] col_h;
        bit [9:0]  fall;
        longint    acc;
        int        tally;
        int        bar_no;
        bit [23:0] smooth[128];
        int        ceiling[128];
        bit [15:0] peak[128];
        bar_result_t pending_bars[$];

        function void clear_ceilings();
            for (int i = 0; i < 128; i++) ceiling[i] = int'($signed(ceil_db)) * 256;
        endfunction

        function void clear_bars();
            acc = 0; tally = 0; bar_no = 0;
            for (int i = 0; i < 128; i++) begin
                smooth[i] = '0;
                peak[i] = '0;
            end
            clear_ceilings();
        endfunction

        function void reset_state();
            bar_count = BAR_COUNT_RST; mode = MODE_RST; attack = ATTACK_RST;
            decay = DECAY_RST; floor_db = FLOOR_RST; ceil_db = CEILING_RST;
            col_h = 12'(COL_H_RST); fall = FALL_RST;
            pending_bars.delete();
            clear_bars();
        endfunction

        function void write_reg(bit [CFG_ADDR_W-1:0] addr, bit [15:0] data);
            case (addr)
                CFG_BAR_COUNT: begin
                    bar_count = data[7:0];
                    clear_bars();
                end
                CFG_MODE_BITS:   mode = data[4:0];
                CFG_ATTACK_RATE: attack = data;
                CFG_DECAY_RATE:  decay = data;
                CFG_DB_FLOOR:    floor_db = data[7:0];
                CFG_DB_CEILING:  ceil_db = data[7:0];
                CFG_COL_HEIGHT: begin
                    col_h = data[11:0];
                    for (int i = 0; i < 128; i++) peak[i] = '0;
                    clear_ceilings();
                end
                CFG_PEAK_FALL:   fall = data[9:0];
                default: ;
            endcase
        endfunction

        // log2 with 16 truncated fraction bits, x > 0
        function longint log2_frac(longint x);
            longint e, m, frac;
            e = 0;
            while (e < 31 && (x >> (e + 1)) != 0) e++;
            m = (e <= 23) ? (x << (23 - e)) : (x >> (e - 23));
            frac = 0;
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 23;
                frac = frac << 1;
                if (m >= (longint'(1) << 24)) begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            return (e << 16) | frac;
        endfunction

        // 20*log10(x/40) in Q8.8, floored at silence
        function int level_db(longint x);
            longint p, q;
            if (x == 0) return DB_SILENCE;
            p = (log2_frac(x) - LOG2_40_OFS) * DB_PER_OCTAVE;
            q = (p + (longint'(1) << 23)) >>> 24;
            if (q < DB_SILENCE) q = DB_SILENCE;
            return int'(q);
        endfunction

        function void note_bin(bit [23:0] l, bit [23:0] r, bit closes, bit fstart);
            int n, idx, flo, ceil_q, c, db, range, num;
            longint v, raw, x, h, cap, height, pk;
            bit [1:0] ch;
            bar_result_t res;
            n = (bar_count < 8) ? 8 : (bar_count > 128 ? 128 : bar_count);
            if (fstart) begin
                acc = 0; tally = 0; bar_no = 0;
            end
            if (bar_no >= n) bar_no = 0;
            ch = mode[4:3];
            v = (ch == CH_LEFT) ? 2 * longint'(l) :
                (ch == CH_RIGHT) ? 2 * longint'(r) : longint'(l) + longint'(r);
            if (tally < 256) begin
                acc += v;
                tally++;
            end
            if (!closes) return;
            idx = bar_no;
            raw = (tally != 0) ? acc / (2 * tally) : 0;
            if (raw > 24'hFFFFFF) raw = 24'hFFFFFF;
            acc = 0; tally = 0;
            x = raw;
            // attack/decay smoothing
            if (mode[1]) begin
                v = smooth[idx];
                if (raw >= v) v = v + ((longint'(attack) * (raw - v) + 32768) >> 16);
                else v = v - ((longint'(decay) * (v - raw) + 32768) >> 16);
                smooth[idx] = v[23:0];
                x = smooth[idx];
            end
            h = col_h;
            cap = (h > TOP_CLEAR) ? h - TOP_CLEAR : 0;
            if (mode[0]) begin
                db = level_db(x);
                flo = int'($signed(floor_db)) * 256;
                ceil_q = int'($signed(ceil_db)) * 256;
                // auto gain: fast attack, slow release
                if (mode[2]) begin
                    c = ceiling[idx];
                    if (db > c) c = db;
                    else begin
                        c -= RELEASE_Q8;
                        if (c < db) c = db;
                    end
                    if (c < flo + 256) c = flo + 256;
                    if (c > 0) c = 0;
                    ceiling[idx] = c;
                    ceil_q = c;
                end
                range = ceil_q - flo;
                if (range < 256) range = 256;
                num = db - flo;
                if (num <= 0) height = 0;
                else if (num >= range) height = h;
                else height = (2 * longint'(num) * h + range) / (2 * longint'(range));
            end else begin
                height = (x >= 65536) ? h : ((x * h + 32768) >> 16);
            end
            if (height > cap) height = cap;
            // peak hold with fall
            pk = peak[idx];
            if ((height << 4) > pk) pk = height << 4;
            else pk = (pk - (height << 4) > fall) ? pk - fall : (height << 4);
            if (pk > (cap << 4)) pk = cap << 4;
            peak[idx] = pk[15:0];
            res.idx = idx[6:0];
            res.height = height[11:0];
            res.peak = 12'((peak[idx] + 16'd8) >> 4);
            res.last = (idx + 1 >= n);
            bar_no = res.last ? 0 : idx + 1;
            pending_bars.insert(pending_bars.size(), res);
        endfunction

        // returns an empty string when the bar matches
        function string check_bar(bar_result_t got);
            bar_result_t want;
            if (pending_bars.size() == 0)
                return $sformatf("unexpected bar %0d", got.idx);
            want = pending_bars.pop_front();
            if (got != want)
                return $sformatf("bar got idx %0d h %0d pk %0d last %0d, want %0d %0d %0d %0d",
                                 got.idx, got.height, got.peak, got.last,
                                 want.idx, want.height, want.peak, want.last);
            return "";
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bar_meter_scoreboard bars = new();
    int  mismatches = 0;
    int  cycles = 0;
    bit  steady = 1'b0;   // no idling on either side

    spectrum_bar_level_meter u_top (.*);

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", cycles, msg);
        mismatches++;
    endtask

    // Timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls and checking
    always @(posedge aclk) begin
        bar_result_t got;
        string msg;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx = m_tdata[6:0];
            got.height = m_tdata[18:7];
            got.peak = m_tdata[30:19];
            got.last = m_tlast;
            msg = bars.check_bar(got);
            if (msg != "") report_mismatch(msg);
        end
        m_tready <= steady || ($urandom_range(99) >= 26);
    end

    task automatic write_reg(bit [CFG_ADDR_W-1:0] addr, bit [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge aclk);
        bars.write_reg(addr, data);
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_bin(bit [23:0] l, bit [23:0] r, bit closes, bit fstart);
        while (!steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        s_tlast <= closes;
        s_tuser <= fstart;
        do @(posedge aclk); while (!s_tready);
        bars.note_bin(l, r, closes, fstart);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bars.pending_bars.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic bit [23:0] rand_mag();
        int k;
        k = $urandom_range(99);
        if (k < 25) return 24'($urandom());
        if (k < 50) return 24'($urandom_range(65535));
        if (k < 70) return 24'($urandom_range(255) << $urandom_range(16));
        if (k < 85) return 24'd0;
        return 24'hFFFFFF;
    endfunction

    // Random register setting; extremes appear often
    task automatic random_setup();
        write_reg(CFG_BAR_COUNT, 16'($urandom_range(3) == 0 ? $urandom_range(255)
                                                            : $urandom_range(8, 12)));
        write_reg(CFG_MODE_BITS, 16'($urandom_range(31)));
        write_reg(CFG_ATTACK_RATE, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom()));
        write_reg(CFG_DECAY_RATE, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom()));
        write_reg(CFG_DB_FLOOR, 16'($urandom_range(9) == 0 ? $urandom_range(255)
                                                           : -$urandom_range(1, 120)));
        write_reg(CFG_DB_CEILING, 16'($urandom_range(9) == 0 ? $urandom_range(255)
                                                             : -$urandom_range(0, 119)));
        write_reg(CFG_COL_HEIGHT, 16'($urandom_range(4) == 0 ? $urandom_range(4095)
                                                             : $urandom_range(0, 300)));
        write_reg(CFG_PEAK_FALL, 16'($urandom()));
        end_writes();
    endtask

    // Mostly whole frames of short bars, with stray frame starts
    task automatic random_bins(int count);
        for (int i = 0; i < count; i++)
            send_bin(rand_mag(), rand_mag(), $urandom_range(2) == 0,
                     $urandom_range(29) == 0);
    endtask

    initial begin
        bars.reset_state();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default dB mode, extremes, silence, channel codes
        send_bin(24'h0, 24'h0, 1'b1, 1'b1);
        send_bin(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_bin(24'h000001, 24'hFFFFFF, 1'b0, 1'b0);
        send_bin(24'h010000, 24'h000000, 1'b1, 1'b0);
        drain();
        write_reg(CFG_MODE_BITS, 5'b11110);   // linear, smoothing, mean (code three)
        write_reg(CFG_COL_HEIGHT, 12'd1);     // too short: all zero
        write_reg(CFG_BAR_COUNT, 8'd0);       // clamps to eight bars
        end_writes();
        for (int i = 0; i < 9; i++) send_bin(24'hFFFFFF, 24'h0, 1'b1, 1'b0);
        drain();
        write_reg(CFG_COL_HEIGHT, 12'd4095);
        write_reg(CFG_MODE_BITS, 5'b01000);   // linear, left
        write_reg(CFG_BAR_COUNT, 8'd255);
        end_writes();
        send_bin(24'h00FFFF, 24'h123456, 1'b1, 1'b0);
        drain();
        write_reg(CFG_MODE_BITS, 5'b10000);   // right
        end_writes();
        send_bin(24'h123456, 24'h008000, 1'b1, 1'b0);
        drain();
        // Overlong bar and positive floor with auto gain
        write_reg(CFG_MODE_BITS, 5'b00101);
        write_reg(CFG_DB_FLOOR, 8'd5);
        write_reg(CFG_DB_CEILING, 8'h89);     // -119 dB
        write_reg(CFG_PEAK_FALL, 10'h3FF);
        end_writes();
        for (int i = 0; i < 270; i++) send_bin(i < 256 ? 24'h100 : 24'hFFFFFF, 24'h0,
                                               i == 269, 1'b0);
        send_bin(24'h000040, 24'h000040, 1'b1, 1'b0);
        drain();

        // Random phases
        for (int p = 0; p < 10; p++) begin
            random_setup();
            steady = (p == 3);
            random_bins(11);
            if (p == 5) begin
                // pause until every pending bar has come out
                s_tvalid <= 1'b0;
                while (bars.pending_bars.size() != 0) @(posedge aclk);
            end
            random_bins(11);
            drain();
        end

        if (mismatches == 0 && bars.pending_bars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### spectrum_bar_level_meter.f
rtl/sbm_pkg.sv
rtl/sbm_ram.sv
rtl/sbm_mul.sv
rtl/sbm_div.sv
rtl/spectrum_bar_level_meter.sv
tb/sv/tb_spectrum_bar_level_meter.sv
